/* hw/rtl/rfhp_pkg.sv */
// ----------------------------------------------------------------------------
// rfhp_pkg
// Shared constants, types and helpers for the RFID hex frame parser.
// ----------------------------------------------------------------------------
package rfhp_pkg;

    localparam int FRAME_BYTES_DEF = 6;

    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] END_BYTE   = 8'h03;

    // one result item as it leaves the parser core
    typedef struct packed {
        logic        valid;
        logic        good;
        logic        error;
        logic [7:0]  version;
        logic [31:0] id;
        logic [7:0]  checksum;
    } result_t;

    // ASCII hex decode: {is_hex, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

/* hw/rtl/rfhp_core.sv */
// ----------------------------------------------------------------------------
// rfhp_core
// Frame state: start hunt, digit pairing, byte store, running XOR.
// Produces the result of the current item combinationally.
// ----------------------------------------------------------------------------
module rfhp_core #(
    parameter int FRAME_BYTES = rfhp_pkg::FRAME_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              acc,
    input  logic [7:0]        rx_byte,
    output rfhp_pkg::result_t res
);
    import rfhp_pkg::*;

    localparam int DIGITS = 2 * FRAME_BYTES;
    localparam int CW     = $clog2(DIGITS + 1);
    localparam int IW     = $clog2(FRAME_BYTES);
    localparam logic [CW-1:0] DIGITS_C = CW'(DIGITS);
    localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_BYTES - 1);

    logic          in_frame_reg, in_frame_next;
    logic [CW-1:0] digit_count_reg, digit_count_next;
    logic [3:0]    high_nibble_reg, high_nibble_next;
    logic [7:0]    xor_reg, xor_next;
    logic [7:0]    bytes_reg [FRAME_BYTES];

    logic [4:0]    hex;
    logic [7:0]    pair_byte;
    logic [IW-1:0] wr_idx;
    logic          is_start, is_end, is_digit, overrun;
    logic          clear_bytes, write_byte;
    logic [7:0]    id_bytes [4];

    assign hex       = hex_decode(rx_byte);
    assign is_start  = (rx_byte == START_BYTE);
    assign is_end    = (rx_byte == END_BYTE);
    assign overrun   = (digit_count_reg >= DIGITS_C);
    assign is_digit  = in_frame_reg && !is_start && !is_end && hex[4] && !overrun;
    assign pair_byte = {high_nibble_reg, hex[3:0]};
    assign wr_idx    = digit_count_reg[IW:1];

    assign clear_bytes = acc && !in_frame_reg && is_start;
    assign write_byte  = acc && is_digit && digit_count_reg[0];

    // id bytes that fall on or past the checksum read as zero
    for (genvar k = 1; k <= 4; k++) begin : g_id
        if (k < FRAME_BYTES - 1) begin : g_byte
            assign id_bytes[k-1] = bytes_reg[k];
        end else begin : g_zero
            assign id_bytes[k-1] = 8'h00;
        end
    end

    always_comb begin
        in_frame_next    = in_frame_reg;
        digit_count_next = digit_count_reg;
        high_nibble_next = high_nibble_reg;
        xor_next         = xor_reg;
        res              = '0;
        if (acc) begin
            if (!in_frame_reg) begin
                if (is_start) begin
                    in_frame_next    = 1'b1;
                    digit_count_next = '0;
                    high_nibble_next = 4'h0;
                    xor_next         = 8'h00;
                end
            end else if (is_start) begin
                // repeated start inside a frame: no effect
            end else if (is_end) begin
                res.valid     = 1'b1;
                res.good      = (xor_reg == bytes_reg[FRAME_BYTES-1]);
                res.error     = (xor_reg != bytes_reg[FRAME_BYTES-1]);
                res.version   = bytes_reg[0];
                res.id        = {id_bytes[0], id_bytes[1], id_bytes[2], id_bytes[3]};
                res.checksum  = bytes_reg[FRAME_BYTES-1];
                in_frame_next = 1'b0;
            end else if (!is_digit) begin
                // non-hex or too many digits: error, resync
                res.valid     = 1'b1;
                res.error     = 1'b1;
                in_frame_next = 1'b0;
            end else begin
                if (!digit_count_reg[0]) begin
                    high_nibble_next = hex[3:0];
                end else begin
                    high_nibble_next = 4'h0;
                    if (wr_idx != LAST_IDX) begin
                        xor_next = xor_reg ^ pair_byte;
                    end
                end
                digit_count_next = digit_count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            digit_count_reg <= '0;
            high_nibble_reg <= 4'h0;
            xor_reg         <= 8'h00;
        end
        else
        begin
            in_frame_reg    <= in_frame_next;
            digit_count_reg <= digit_count_next;
            high_nibble_reg <= high_nibble_next;
            xor_reg         <= xor_next;
        end
    end

    // frame byte store: cleared at each start that opens a frame, one byte per digit pair
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            if (clear_bytes)
            begin
                bytes_reg[i] <= 8'h00;
            end
            else if (write_byte && wr_idx == IW'(i))
            begin
                bytes_reg[i] <= pair_byte;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= DIGITS_C)
        else $error("digit count past frame length");

    a_result_only_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> in_frame_reg)
        else $error("result outside a frame");

    a_result_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |=> !in_frame_reg)
        else $error("frame still open after result");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.good ^ res.error))
        else $error("good and error flags disagree");

    a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
        clear_bytes |=> (in_frame_reg && digit_count_reg == '0 && xor_reg == 8'h00))
        else $error("start byte did not open a clean frame");
`endif

endmodule

/* hw/rtl/rfid_hex_frame_parser.sv */
// ----------------------------------------------------------------------------
// rfid_hex_frame_parser
// Parses ASCII hex frames from a card reader into version, id and checksum,
// with XOR check, overrun and bad-character detection.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | rx_byte
//  out      | out_valid / out_ready| frame_good, frame_error, tag_version,
//           |                      | tag_id, tag_checksum
//
//  One byte is accepted per cycle while in_ready is high. Frame state updates at the accepting edge;
//  a result (end byte, overrun or bad character) lands in the output register
//  at that same edge and is offered from the next cycle.
//  The output register is the only buffer: in_ready drops only while a result
//  is held and out_ready is low, so a stalled sink stalls the byte stream.
//  Reset (rst_n low, async) returns to hunting for a start byte, output empty.
//
module rfid_hex_frame_parser #(
    parameter int FRAME_BYTES = rfhp_pkg::FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_good,
    output logic        frame_error,
    output logic [7:0]  tag_version,
    output logic [31:0] tag_id,
    output logic [7:0]  tag_checksum
);
    import rfhp_pkg::*;

    logic    acc;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg, out_valid_next;

    // slot free when empty or being drained this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign acc      = in_valid && in_ready;

    rfhp_core #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .acc    (acc),
        .rx_byte(rx_byte),
        .res    (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (acc) begin
            out_valid_next = res.valid;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only when a result is produced
    always_ff @(posedge clk)
    begin
        if (acc && res.valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_good   = res_reg.good;
    assign frame_error  = res_reg.error;
    assign tag_version  = res_reg.version;
    assign tag_id       = res_reg.id;
    assign tag_checksum = res_reg.checksum;

endmodule
